// ===== hw/rtl/program_stream_pes_extractor_assert.svh =====
// Assertion macros shared by the program stream extractor RTL.
// Relies on the clock and reset port names of the modules that include it.
`ifndef PROGRAM_STREAM_PES_EXTRACTOR_ASSERT_SVH
`define PROGRAM_STREAM_PES_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PSX_ASSERT_IMP(label, cond, expect_now) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |-> (expect_now)) else $error("psx: assertion failed");

// Next-cycle implication, checked outside reset
`define PSX_ASSERT_NXT(label, cond, expect_next) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> (expect_next)) else $error("psx: assertion failed");

`endif

// ===== hw/rtl/psx_pkg.sv =====
// Shared types and constants for the program stream PES extractor.
// No dependencies; imported by psx_parser and the top level.
package psx_pkg;

   localparam int unsigned PTS_W = 33;

   // Configuration register indexes
   localparam logic CSR_VIDEO_ID   = 1'b0;
   localparam logic CSR_PRIVATE_ID = 1'b1;

   // Reset values of the stream id registers
   localparam logic [7:0] VIDEO_ID_RESET   = 8'hE0;
   localparam logic [7:0] PRIVATE_ID_RESET = 8'hBD;

   // Result status codes
   localparam logic STATUS_PAYLOAD  = 1'b0;
   localparam logic STATUS_NO_START = 1'b1;

   typedef struct packed {
      logic             valid;
      logic             status;
      logic [7:0]       payload_byte;
      logic [15:0]      stream_id;
      logic [PTS_W-1:0] pts;
      logic             first_of_payload;
      logic             last_of_payload;
   } psx_result_type;

endpackage

// ===== hw/rtl/program_stream_pes_extractor.sv =====
// Top level of the MPEG-2 program stream PES extractor.
// Depends on psx_pkg, psx_parser and program_stream_pes_extractor_assert.svh.
//
// Feed the block one byte of a program stream pack per transfer on req_, with req_tlast on
// the pack's final byte. It checks the 00 00 01 BA pack start code, skips the pack header,
// stuffing and an optional system header, then walks the PES packets. Payload bytes of the
// video and private streams leave on rsp_ one per transfer, tagged with stream id (substream
// in the high byte for the private stream), 33-bit PTS (zero when absent) and first/last
// marks; a pack that lacks its start code yields a single error transfer (rsp_tuser[0]
// high, all other fields zero) and the rest of that pack is dropped. The parse state
// advances at the input transfer and the result, if any, is held in the output register
// from the next cycle. One byte per cycle is sustained; the only back-pressure is a result
// still held in the output register while rsp_tready is low. Stream id registers (csr_
// index 0 video id, 1 private id) are for the user to write only while the stream is idle,
// which the block does not enforce; no clearing pass is needed after reset.
`include "program_stream_pes_extractor_assert.svh"

module program_stream_pes_extractor (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // pack_last
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] payload_byte, [23:8] stream_id, [56:24] pts
   output logic [1:0]  rsp_tuser,   // [0] status, [1] first_of_payload
   output logic        rsp_tlast,   // last_of_payload
   // configuration
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata
);
   import psx_pkg::*;

   logic           req_xfer;
   psx_result_type step_result;

   logic           rsp_valid_ff, rsp_valid_in;
   psx_result_type rsp_ff;
   logic [7:0]     video_id_ff;
   logic [7:0]     private_id_ff;

   logic           rsp_is_error;
   logic           rsp_fields_clear;

   // accept a byte whenever the output register is empty or drains this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   psx_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_en    (req_xfer),
      .data_byte  (req_tdata),
      .pack_last  (req_tlast),
      .video_id   (video_id_ff),
      .private_id (private_id_ff),
      .result     (step_result)
   );

   // stream id registers: write-only, take effect at the next packet start
   always_ff @(posedge clock) begin
      if (reset) begin
         video_id_ff   <= VIDEO_ID_RESET;
         private_id_ff <= PRIVATE_ID_RESET;
      end else if (csr_we) begin
         if (csr_addr == CSR_VIDEO_ID)   video_id_ff   <= csr_wdata;
         if (csr_addr == CSR_PRIVATE_ID) private_id_ff <= csr_wdata;
      end
   end

   // output register: load on an input transfer, drop once the result is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer)        rsp_valid_in = step_result.valid;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   // payload needs no reset; hold it unless a new byte is transferred
   always_ff @(posedge clock) begin
      if (req_xfer) rsp_ff <= step_result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.pts, rsp_ff.stream_id, rsp_ff.payload_byte};
   assign rsp_tuser  = {rsp_ff.first_of_payload, rsp_ff.status};
   assign rsp_tlast  = rsp_ff.last_of_payload;

   assign rsp_is_error     = rsp_tvalid && (rsp_tuser[0] == STATUS_NO_START);
   assign rsp_fields_clear = (rsp_tdata == 64'd0) && !rsp_tuser[1] && !rsp_tlast;

   `PSX_ASSERT_IMP(a_error_fields_clear, rsp_is_error, rsp_fields_clear)
   `PSX_ASSERT_IMP(a_stall_only_when_full, !req_tready, rsp_tvalid)
   `PSX_ASSERT_IMP(a_result_from_transfer, $rose(rsp_tvalid), $past(req_tvalid && req_tready))

endmodule

// ===== hw/rtl/psx_parser.sv =====
// Byte-wise parse state of the program stream: pack header, system header, PES packets.
// Depends on psx_pkg and program_stream_pes_extractor_assert.svh.
`include "program_stream_pes_extractor_assert.svh"

module psx_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [7:0]              data_byte,
   input  logic                    pack_last,
   input  logic [7:0]              video_id,
   input  logic [7:0]              private_id,
   output psx_pkg::psx_result_type result
);
   import psx_pkg::*;

   localparam logic [4:0] PH_PACK_SC    = 5'd0;
   localparam logic [4:0] PH_PACK_HDR   = 5'd1;
   localparam logic [4:0] PH_STUFF_LEN  = 5'd2;
   localparam logic [4:0] PH_STUFF      = 5'd3;
   localparam logic [4:0] PH_CODE_FIRST = 5'd4;
   localparam logic [4:0] PH_CODE_PES   = 5'd5;
   localparam logic [4:0] PH_SYS_LEN    = 5'd6;
   localparam logic [4:0] PH_SKIP       = 5'd7;
   localparam logic [4:0] PH_PES_LEN    = 5'd8;
   localparam logic [4:0] PH_DISCARD    = 5'd9;
   localparam logic [4:0] PH_FLAGS1     = 5'd10;
   localparam logic [4:0] PH_FLAGS2     = 5'd11;
   localparam logic [4:0] PH_HDR_LEN    = 5'd12;
   localparam logic [4:0] PH_HDR_DATA   = 5'd13;
   localparam logic [4:0] PH_SUB        = 5'd14;
   localparam logic [4:0] PH_PAYLOAD    = 5'd15;
   localparam logic [4:0] PH_IGNORE     = 5'd16;

   localparam logic [7:0]  PACK_CODE_ID   = 8'hBA;
   localparam logic [7:0]  SYS_HDR_ID     = 8'hBB;
   localparam logic [23:0] START_PREFIX   = 24'h000001;
   localparam logic [15:0] PACK_HDR_BYTES = 16'd9;

   logic [4:0]       phase_ff, phase_in;
   logic [15:0]      cnt_ff, cnt_in;
   logic [15:0]      rem_ff, rem_in;
   logic [23:0]      win_ff, win_in;
   logic [15:0]      stream_ff, stream_in;
   logic [PTS_W-1:0] pts_ff, pts_in;
   logic             pts_present_ff, pts_present_in;
   logic             started_ff, started_in;
   logic             private_ff, private_in;

   logic [16:0]      cnt_inc;
   logic [15:0]      cnt_dec;
   logic [15:0]      len_word;
   logic [7:0]       pack_code_byte;
   logic             bounded;
   logic             pes_private;

   always_comb begin
      cnt_inc     = {1'b0, cnt_ff} + 17'd1;
      cnt_dec     = (cnt_ff != 16'd0) ? cnt_ff - 16'd1 : cnt_ff;
      len_word    = {rem_ff[7:0], data_byte};
      bounded     = (phase_ff >= PH_FLAGS1) && (phase_ff <= PH_PAYLOAD);
      pes_private = (data_byte == private_id);
      case (cnt_ff[1:0])
         2'd2:    pack_code_byte = 8'h01;
         2'd3:    pack_code_byte = PACK_CODE_ID;
         default: pack_code_byte = 8'h00;
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      cnt_in         = cnt_ff;
      rem_in         = rem_ff;
      win_in         = win_ff;
      stream_in      = stream_ff;
      pts_in         = pts_ff;
      pts_present_in = pts_present_ff;
      started_in     = started_ff;
      private_in     = private_ff;
      result         = '0;

      case (phase_ff)
         PH_PACK_SC: begin
            if (data_byte != pack_code_byte) begin
               result.valid  = 1'b1;
               result.status = STATUS_NO_START;
               phase_in      = PH_IGNORE;
            end else if (cnt_inc >= 17'd4) begin
               phase_in = PH_PACK_HDR;
               cnt_in   = PACK_HDR_BYTES;
            end else begin
               cnt_in = cnt_inc[15:0];
            end
         end
         PH_PACK_HDR: begin
            cnt_in = cnt_dec;
            if (cnt_dec == 16'd0) phase_in = PH_STUFF_LEN;
         end
         PH_STUFF_LEN: begin
            cnt_in = {13'd0, data_byte[2:0]};
            if (data_byte[2:0] == 3'd0) begin
               phase_in = PH_CODE_FIRST;
               cnt_in   = '0;
               win_in   = '0;
            end else begin
               phase_in = PH_STUFF;
            end
         end
         PH_STUFF, PH_SKIP: begin
            cnt_in = cnt_dec;
            if (cnt_dec == 16'd0) begin
               phase_in = (phase_ff == PH_STUFF) ? PH_CODE_FIRST : PH_CODE_PES;
               win_in   = '0;
            end
         end
         PH_CODE_FIRST, PH_CODE_PES: begin
            if (cnt_ff < 16'd3) begin
               win_in = {win_ff[15:0], data_byte};
               cnt_in = cnt_inc[15:0];
            end else if (win_ff != START_PREFIX) begin
               phase_in = PH_IGNORE;
            end else if (phase_ff == PH_CODE_FIRST && data_byte == SYS_HDR_ID) begin
               phase_in = PH_SYS_LEN;
               cnt_in   = '0;
               rem_in   = '0;
            end else begin
               // new PES packet: latch the stream it belongs to
               private_in     = pes_private;
               stream_in      = (pes_private || data_byte == video_id) ?
                                {8'd0, data_byte} : 16'd0;
               pts_in         = '0;
               pts_present_in = 1'b0;
               started_in     = 1'b0;
               rem_in         = '0;
               cnt_in         = '0;
               phase_in       = PH_PES_LEN;
            end
         end
         PH_SYS_LEN: begin
            rem_in = len_word;
            cnt_in = cnt_inc[15:0];
            if (cnt_ff >= 16'd1) begin
               cnt_in = len_word;
               rem_in = '0;
               if (len_word == 16'd0) begin
                  phase_in = PH_CODE_PES;
                  win_in   = '0;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_PES_LEN: begin
            rem_in = len_word;
            cnt_in = cnt_inc[15:0];
            if (cnt_ff >= 16'd1) begin
               cnt_in = '0;
               if (len_word == 16'd0) begin
                  phase_in = PH_CODE_PES;
                  win_in   = '0;
               end else if (stream_ff != 16'd0 || private_ff) begin
                  phase_in = PH_FLAGS1;
               end else begin
                  phase_in = PH_DISCARD;
               end
            end
         end
         PH_DISCARD: begin
            rem_in = (rem_ff != 16'd0) ? rem_ff - 16'd1 : rem_ff;
            if (rem_in == 16'd0) begin
               phase_in = PH_CODE_PES;
               cnt_in   = '0;
               win_in   = '0;
            end
         end
         PH_FLAGS1: phase_in = PH_FLAGS2;
         PH_FLAGS2: begin
            pts_present_in = data_byte[7];
            phase_in       = PH_HDR_LEN;
         end
         PH_HDR_LEN: begin
            win_in = {16'd0, data_byte};
            cnt_in = '0;
            if (data_byte == 8'd0) phase_in = private_ff ? PH_SUB : PH_PAYLOAD;
            else                   phase_in = PH_HDR_DATA;
         end
         PH_HDR_DATA: begin
            if (pts_present_ff) begin
               case (cnt_ff)
                  16'd0:   pts_in = pts_ff | {data_byte[3:1], 30'd0};
                  16'd1:   pts_in = pts_ff | {3'd0, data_byte, 22'd0};
                  16'd2:   pts_in = pts_ff | {11'd0, data_byte[7:1], 15'd0};
                  16'd3:   pts_in = pts_ff | {18'd0, data_byte, 7'd0};
                  16'd4:   pts_in = pts_ff | {26'd0, data_byte[7:1]};
                  default: pts_in = pts_ff;
               endcase
            end
            cnt_in = cnt_inc[15:0];
            if ({7'd0, cnt_inc} >= win_ff) begin
               cnt_in   = '0;
               phase_in = private_ff ? PH_SUB : PH_PAYLOAD;
            end
         end
         PH_SUB: begin
            if (cnt_ff == 16'd0) stream_in = {data_byte, stream_ff[7:0]};
            cnt_in = cnt_inc[15:0];
            if (cnt_inc >= 17'd4) begin
               cnt_in   = '0;
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            result.valid            = 1'b1;
            result.status           = STATUS_PAYLOAD;
            result.payload_byte     = data_byte;
            result.stream_id        = stream_ff;
            result.pts              = pts_present_ff ? pts_ff : '0;
            result.first_of_payload = !started_ff;
            result.last_of_payload  = (rem_ff <= 16'd1) || pack_last;
            started_in              = 1'b1;
         end
         default: phase_in = PH_IGNORE;
      endcase

      // count down the PES packet length while inside the packet
      if (bounded) begin
         rem_in = (rem_ff != 16'd0) ? rem_ff - 16'd1 : rem_ff;
         if (rem_in == 16'd0) begin
            phase_in = PH_CODE_PES;
            cnt_in   = '0;
            win_in   = '0;
         end
      end

      if (pack_last) begin
         if (phase_in == PH_PACK_SC && !result.valid) begin
            result.valid  = 1'b1;
            result.status = STATUS_NO_START;
         end
         phase_in   = PH_PACK_SC;
         cnt_in     = '0;
         rem_in     = '0;
         win_in     = '0;
         started_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_PACK_SC;
         cnt_ff         <= '0;
         rem_ff         <= '0;
         win_ff         <= '0;
         stream_ff      <= '0;
         pts_ff         <= '0;
         pts_present_ff <= 1'b0;
         started_ff     <= 1'b0;
         private_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         cnt_ff         <= cnt_in;
         rem_ff         <= rem_in;
         win_ff         <= win_in;
         stream_ff      <= stream_in;
         pts_ff         <= pts_in;
         pts_present_ff <= pts_present_in;
         started_ff     <= started_in;
         private_ff     <= private_in;
      end
   end

   `PSX_ASSERT_IMP(a_bounded_has_length, bounded, rem_ff != 16'd0)
   `PSX_ASSERT_NXT(a_last_restarts_pack, step_en && pack_last, phase_ff == PH_PACK_SC)
   `PSX_ASSERT_IMP(a_pack_sc_index, phase_ff == PH_PACK_SC, cnt_ff <= 16'd3)

endmodule
